>>> sv/usg_pkg.sv
// Package for the UV sphere point generator: sequencer states, widths and the
// CORDIC arctangent table. No dependencies.
package usg_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int TRIG_W = 34;   // sin/cos in Q2.30 with headroom
  localparam int PROD_W = 38;   // rounded product after the >>30
  localparam int DIV_STEPS = 42;
  localparam logic [33:0] CORDIC_X0 = 34'd652032874;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_CLAT, ST_CLON, ST_MT, ST_MX, ST_MY, ST_MZ, ST_OUT
  } usg_state_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0, REG_CX = 3'd1, REG_CY = 3'd2, REG_CZ = 3'd3, REG_SEG = 3'd4
  } usg_reg_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] k);
    case (k)
      5'd0: atan_lut = 30'h20000000;  5'd1: atan_lut = 30'h12E4051E;
      5'd2: atan_lut = 30'h09FB385B;  5'd3: atan_lut = 30'h051111D4;
      5'd4: atan_lut = 30'h028B0D43;  5'd5: atan_lut = 30'h0145D7E1;
      5'd6: atan_lut = 30'h00A2F61E;  5'd7: atan_lut = 30'h00517C55;
      5'd8: atan_lut = 30'h0028BE53;  5'd9: atan_lut = 30'h00145F2F;
      5'd10: atan_lut = 30'h000A2F98; 5'd11: atan_lut = 30'h000517CC;
      5'd12: atan_lut = 30'h00028BE6; 5'd13: atan_lut = 30'h000145F3;
      5'd14: atan_lut = 30'h0000A2FA; 5'd15: atan_lut = 30'h0000517D;
      5'd16: atan_lut = 30'h000028BE; 5'd17: atan_lut = 30'h0000145F;
      5'd18: atan_lut = 30'h00000A30; 5'd19: atan_lut = 30'h00000518;
      5'd20: atan_lut = 30'h0000028C; 5'd21: atan_lut = 30'h00000146;
      5'd22: atan_lut = 30'h000000A3; 5'd23: atan_lut = 30'h00000051;
      5'd24: atan_lut = 30'h00000029; 5'd25: atan_lut = 30'h00000014;
      5'd26: atan_lut = 30'h0000000A; 5'd27: atan_lut = 30'h00000005;
      5'd28: atan_lut = 30'h00000003; 5'd29: atan_lut = 30'h00000001;
      5'd30: atan_lut = 30'h00000001;
      default: atan_lut = 30'h00000000;
    endcase
  endfunction

endpackage

>>> sv/usg_div.sv
// Two-lane restoring divider that turns grid indices into 32-bit phases.
// Depends on usg_pkg.
module usg_div import usg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [9:0]  lat_idx,
  input  logic [9:0]  lon_idx,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [31:0] lat_ph,
  output logic [31:0] lon_ph
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [41:0] dva_r, dvb_r;
  logic [9:0]  rema_r, remb_r;
  logic [31:0] qa_r, qb_r;
  logic [10:0] ra, rb;
  logic        gea, geb;

  assign ra  = {rema_r, dva_r[41]};
  assign rb  = {remb_r, dvb_r[41]};
  assign gea = ra >= {1'b0, divisor};
  assign geb = rb >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dva_r  <= {1'b0, lat_idx, 31'd0};
      dvb_r  <= {lon_idx, 32'd0};
      rema_r <= '0;
      remb_r <= '0;
    end else if (busy_r) begin
      dva_r  <= {dva_r[40:0], 1'b0};
      dvb_r  <= {dvb_r[40:0], 1'b0};
      rema_r <= gea ? 10'(ra - {1'b0, divisor}) : ra[9:0];
      remb_r <= geb ? 10'(rb - {1'b0, divisor}) : rb[9:0];
      qa_r   <= {qa_r[30:0], gea};
      qb_r   <= {qb_r[30:0], geb};
    end
  end

  assign done   = done_r;
  assign lat_ph = qa_r;
  assign lon_ph = qb_r;

endmodule

>>> sv/usg_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// quadrant correction on the way out. Depends on usg_pkg.
module usg_cordic import usg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              phase,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic                     busy_r, done_r;
  logic [4:0]               k_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_r, y_r, dx, dy;
  logic signed [32:0]       z_r, at;

  assign dx = y_r >>> k_r;
  assign dy = x_r >>> k_r;
  assign at = signed'({3'b000, atan_lut(k_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_r == 5'(CORDIC_STAGES - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= signed'(CORDIC_X0);
      y_r    <= '0;
      z_r    <= signed'({3'b000, phase[29:0]});
      quad_r <= phase[31:30];
      k_r    <= '0;
    end else if (busy_r) begin
      k_r <= k_r + 5'd1;
      if (!z_r[32]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  always_comb begin
    case (quad_r)
      2'd0: begin cos_o = x_r;  sin_o = y_r;  end
      2'd1: begin cos_o = -y_r; sin_o = x_r;  end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  assign done = done_r;

endmodule

>>> sv/usg_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle, with the Q30
// rounding shift on the result. Depends on usg_pkg.
module usg_mul import usg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [TRIG_W-1:0] a,
  input  logic signed [TRIG_W-1:0] b,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  localparam int ACC_W = 2 * TRIG_W;

  logic                    busy_r, done_r;
  logic [5:0]              k_r;
  logic signed [ACC_W-1:0] acc_r, ash_r, rnd;
  logic [TRIG_W-1:0]       b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_r == 6'(TRIG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The top multiplier bit carries negative weight, so it subtracts.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      ash_r <= ACC_W'(a);
      b_r   <= b;
      k_r   <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= (k_r == 6'(TRIG_W - 1)) ? acc_r - ash_r : acc_r + ash_r;
      end
      ash_r <= ash_r <<< 1;
      b_r   <= b_r >> 1;
      k_r   <= k_r + 6'd1;
    end
  end

  assign rnd  = acc_r + ACC_W'(64'sd536870912);
  assign prod = rnd[30 +: PROD_W];
  assign done = done_r;

endmodule

>>> sv/uv_sphere_point_generator_top.sv
// UV sphere point generator top: APB registers, grid counters, sequencer.
// A word passes through the 42-step divider, two 18-step CORDIC passes and four
// 34-step multiplies before the result is loaded.
// One word in flight; the input stalls until the result is loaded.
// Synchronous active-low reset restores register defaults and clears the grid.
// Depends on usg_pkg, usg_div, usg_cordic, usg_mul.
module uv_sphere_point_generator_top import usg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic [9:0]  out_lat_step,
  output logic [9:0]  out_lon_step,
  output logic        out_grid_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  usg_state_t state_r, state_nxt;

  logic [30:0] radius_r;
  logic [31:0] cx_r, cy_r, cz_r;
  logic [9:0]  seg_r;

  logic [9:0]  lat_cnt_r, lon_cnt_r, i_r, j_r, n_r, ci, cj, nn;
  logic        gdone_r, accept, start_r, start_nxt, out_load;
  logic [31:0] lat_ph_r, lon_ph_r;
  logic signed [TRIG_W-1:0] clat_r, slat_r, clon_r, slon_r, t_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [TRIG_W-1:0] ma, mb, cor_c, cor_s;
  logic signed [PROD_W-1:0] mprod;
  logic [31:0] cor_ph, div_lat, div_lon;
  logic        div_done, cor_done, mul_done;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      seg_r    <= 10'd200;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_RADIUS: radius_r <= pwdata[30:0];
        REG_CX:     cx_r     <= pwdata;
        REG_CY:     cy_r     <= pwdata;
        REG_CZ:     cz_r     <= pwdata;
        REG_SEG:    seg_r    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_RADIUS: prdata = {1'b0, radius_r};
      REG_CX:     prdata = cx_r;
      REG_CY:     prdata = cy_r;
      REG_CZ:     prdata = cz_r;
      REG_SEG:    prdata = {22'd0, seg_r};
      default:    prdata = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ci       = in_restart ? 10'd0 : lat_cnt_r;
  assign cj       = in_restart ? 10'd0 : lon_cnt_r;
  assign nn       = (seg_r == 10'd0) ? 10'd1 : seg_r;

  // Grid walk: the counters advance as soon as a word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_cnt_r <= '0;
      lon_cnt_r <= '0;
    end else if (accept) begin
      if (cj >= nn) begin
        lon_cnt_r <= '0;
        lat_cnt_r <= (ci >= nn) ? 10'd0 : ci + 10'd1;
      end else begin
        lat_cnt_r <= ci;
        lon_cnt_r <= cj + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r     <= ci;
      j_r     <= cj;
      n_r     <= nn;
      gdone_r <= (ci >= nn) && (cj >= nn);
    end
    if (state_r == ST_DIV && div_done) begin
      lat_ph_r <= div_lat;
      lon_ph_r <= div_lon;
    end
    if (state_r == ST_CLAT && cor_done) begin
      clat_r <= cor_c;
      slat_r <= cor_s;
    end
    if (state_r == ST_CLON && cor_done) begin
      clon_r <= cor_c;
      slon_r <= cor_s;
    end
    if (state_r == ST_MT && mul_done) t_r  <= mprod[TRIG_W-1:0];
    if (state_r == ST_MX && mul_done) px_r <= mprod;
    if (state_r == ST_MY && mul_done) py_r <= mprod;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_CLAT;
      ST_CLAT: if (cor_done) state_nxt = ST_CLON;
      ST_CLON: if (cor_done) state_nxt = ST_MT;
      ST_MT:   if (mul_done) state_nxt = ST_MX;
      ST_MX:   if (mul_done) state_nxt = ST_MY;
      ST_MY:   if (mul_done) state_nxt = ST_MZ;
      ST_MZ:   if (mul_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start_nxt = (state_nxt != state_r) && (state_nxt != ST_IDLE) && (state_nxt != ST_OUT);
    cor_ph    = (state_r == ST_CLAT) ? lat_ph_r : lon_ph_r;
    case (state_r)
      ST_MX:   begin ma = t_r; mb = clon_r; end
      ST_MY:   begin ma = t_r; mb = slon_r; end
      ST_MZ:   begin ma = signed'({3'b000, radius_r}); mb = clat_r; end
      default: begin ma = signed'({3'b000, radius_r}); mb = slat_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  usg_div u_div (
    .clk, .rst_n,
    .start   (start_r && state_r == ST_DIV),
    .lat_idx (i_r),
    .lon_idx (j_r),
    .divisor (n_r),
    .done    (div_done),
    .lat_ph  (div_lat),
    .lon_ph  (div_lon)
  );

  usg_cordic u_cordic (
    .clk, .rst_n,
    .start (start_r && (state_r == ST_CLAT || state_r == ST_CLON)),
    .phase (cor_ph),
    .done  (cor_done),
    .cos_o (cor_c),
    .sin_o (cor_s)
  );

  usg_mul u_mul (
    .clk, .rst_n,
    .start (start_r && (state_r == ST_MT || state_r == ST_MX ||
                        state_r == ST_MY || state_r == ST_MZ)),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (mprod)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] c,
                                          input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = (PROD_W + 1)'(signed'(c)) + (PROD_W + 1)'(p);
    if (s > (PROD_W + 1)'(64'sd2147483647)) sat_add = 32'h7FFFFFFF;
    else if (s < (PROD_W + 1)'(-64'sd2147483648)) sat_add = 32'h80000000;
    else sat_add = s[31:0];
  endfunction

  // The z product waits in its own register until the output load.
  logic signed [PROD_W-1:0] pz_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_MZ && mul_done) pz_r <= mprod;
  end

  logic out_valid_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_point_x   <= sat_add(cx_r, px_r);
      out_point_y   <= sat_add(cy_r, py_r);
      out_point_z   <= sat_add(cz_r, pz_r);
      out_lat_step  <= i_r;
      out_lon_step  <= j_r;
      out_grid_done <= gdone_r;
    end
  end

endmodule

>>> sv/usg_checker.sv
// Port-level checker for the UV sphere point generator, bound to the top.
// Depends on uv_sphere_point_generator_top.
module usg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [31:0] out_point_x
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x))
    else $error("stalled result word changed");

  // A taken result is followed by an empty output unless the next word loaded with it.
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid || !in_stall)
    else $error("result word repeated");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left output valid or sequencer busy");

endmodule

bind uv_sphere_point_generator_top usg_checker u_usg_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_point_x
);
